// ===== src/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/pspr_pkg.sv =====
// ----------------------------------------------------------------------------
// pspr_pkg
// Types and constants for the power-of-two strength reduction unit.
// ----------------------------------------------------------------------------
package pspr_pkg;

  localparam int FIELD_BITS  = 32;
  localparam int EXP_W       = $clog2(FIELD_BITS);
  localparam int CODE_W      = 8;
  localparam int CFG_ADDR_W  = 5;
  localparam int CFG_DATA_W  = 32;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  typedef logic signed [FIELD_BITS-1:0] field_t;
  typedef logic [CODE_W-1:0]            code_t;

  // Configuration register indexes (byte address = 4 * index)
  typedef enum logic [2:0] {
    REG_LOAD_IMM  = 3'd0,
    REG_MULTIPLY  = 3'd1,
    REG_DIVIDE    = 3'd2,
    REG_SHL_IMM   = 3'd3,
    REG_SHR_IMM   = 3'd4
  } reg_idx_t;

  localparam code_t RST_LOAD_IMM = 8'd0;
  localparam code_t RST_MULTIPLY = 8'd1;
  localparam code_t RST_DIVIDE   = 8'd2;
  localparam code_t RST_SHL_IMM  = 8'd3;
  localparam code_t RST_SHR_IMM  = 8'd4;

  typedef struct packed {
    code_t load_imm;
    code_t multiply;
    code_t divide;
    code_t shl_imm;
    code_t shr_imm;
  } cfg_t;

  typedef struct packed {
    code_t  code;
    field_t f1;
    field_t f2;
    field_t f3;
  } insn_t;

  typedef struct packed {
    code_t  op_code;
    field_t operand_a;
    field_t operand_b;
    field_t operand_c;
    logic   end_of_stream;
  } in_item_t;

  typedef struct packed {
    code_t  out_op_code;
    field_t out_operand_a;
    field_t out_operand_b;
    field_t out_operand_c;
    logic   out_last;
  } out_item_t;

  // Results caused by one accepted instruction, oldest in slot 0
  typedef struct packed {
    logic [1:0]  cnt;
    logic        eos;
    insn_t [2:0] slot;
  } bundle_t;

endpackage

// ===== src/pspr_cfg.sv =====
// ----------------------------------------------------------------------------
// pspr_cfg
// APB-style register file holding the five opcode values.
// ----------------------------------------------------------------------------
module pspr_cfg import pspr_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready,
  output cfg_t                  cfg
);

  cfg_t     cfg_r;
  cfg_t     cfg_nxt;
  reg_idx_t idx;
  logic     wr_en;
  code_t    wr_code;
  code_t    rd_code;

  assign idx     = reg_idx_t'(paddr[CFG_ADDR_W-1:2]);
  assign wr_en   = psel && penable && pwrite;
  assign wr_code = pwdata[CODE_W-1:0];
  assign pready  = 1'b1;
  assign cfg     = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (idx)
        REG_LOAD_IMM: cfg_nxt.load_imm = wr_code;
        REG_MULTIPLY: cfg_nxt.multiply = wr_code;
        REG_DIVIDE:   cfg_nxt.divide   = wr_code;
        REG_SHL_IMM:  cfg_nxt.shl_imm  = wr_code;
        REG_SHR_IMM:  cfg_nxt.shr_imm  = wr_code;
        default:      cfg_nxt = cfg_r;  // drop writes past the list
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_LOAD_IMM: rd_code = cfg_r.load_imm;
      REG_MULTIPLY: rd_code = cfg_r.multiply;
      REG_DIVIDE:   rd_code = cfg_r.divide;
      REG_SHL_IMM:  rd_code = cfg_r.shl_imm;
      REG_SHR_IMM:  rd_code = cfg_r.shr_imm;
      default:      rd_code = '0;
    endcase
  end

  assign prdata = {{(CFG_DATA_W-CODE_W){1'b0}}, rd_code};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.load_imm <= RST_LOAD_IMM;
      cfg_r.multiply <= RST_MULTIPLY;
      cfg_r.divide   <= RST_DIVIDE;
      cfg_r.shl_imm  <= RST_SHL_IMM;
      cfg_r.shr_imm  <= RST_SHR_IMM;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

// ===== src/pspr_front.sv =====
// ----------------------------------------------------------------------------
// pspr_front
// Holds the two-instruction window, rewrites each completed window and
// packs the instructions that leave into at most one bundle per transaction.
// ----------------------------------------------------------------------------
module pspr_front import pspr_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  cfg_t     cfg,
  input  logic     push,
  input  in_item_t in_item,
  input  logic     q_full,
  output logic     full,
  output logic     q_push,
  output bundle_t  q_data
);

  insn_t      win_r   [2];
  insn_t      win_nxt [2];
  logic [1:0] fill_r;
  logic [1:0] fill_nxt;
  logic       accept;
  insn_t      x;
  insn_t      pa;
  insn_t      pb;
  insn_t      pc;
  logic       ok_a;
  logic       ok_b;
  logic [EXP_W-1:0] exp_a;
  logic [EXP_W-1:0] exp_b;

  function automatic logic pow2_ok(field_t v);
    logic [FIELD_BITS-1:0] u;
    u = v;
    return (u != '0) && !u[FIELD_BITS-1] && ((u & (u - 1'b1)) == '0);
  endfunction

  function automatic logic [EXP_W-1:0] pow2_exp(field_t v);
    logic [EXP_W-1:0] e;
    e = '0;
    for (int i = 0; i < FIELD_BITS; i++) begin
      if (v[i]) e = e | EXP_W'(i);
    end
    return e;
  endfunction

  function automatic insn_t reduce(insn_t tgt, insn_t ld, logic ok,
                                   logic [EXP_W-1:0] e, code_t new_code,
                                   logic mul);
    insn_t t;
    t = tgt;
    if (ok) begin
      t.code = new_code;
      if (mul && ld.f2 == t.f1) t.f1 = t.f2;
      t.f2 = field_t'({{(FIELD_BITS-EXP_W){1'b0}}, e});
    end
    return t;
  endfunction

  assign accept = push && !q_full;
  assign full   = q_full;

  assign x.code = in_item.op_code;
  assign x.f1   = in_item.operand_a;
  assign x.f2   = in_item.operand_b;
  assign x.f3   = in_item.operand_c;

  // Loaded constants are never touched by a rewrite before they are used
  assign ok_a  = pow2_ok(win_r[0].f1);
  assign ok_b  = pow2_ok(win_r[1].f1);
  assign exp_a = pow2_exp(win_r[0].f1);
  assign exp_b = pow2_exp(win_r[1].f1);

  // Window checks in fixed order; each rewrite feeds the next check
  always_comb begin
    pa = win_r[0];
    pb = win_r[1];
    pc = x;
    if (pa.code == cfg.load_imm || pb.code == cfg.load_imm) begin
      if (pc.code == cfg.divide || pb.code == cfg.divide) begin
        if (pb.code == cfg.load_imm && pb.f2 == pc.f2)
          pc = reduce(pc, pb, ok_b, exp_b, cfg.shr_imm, 1'b0);
        if (pa.code == cfg.load_imm) begin
          if (pb.code == cfg.divide && pa.f2 == pb.f2)
            pb = reduce(pb, pa, ok_a, exp_a, cfg.shr_imm, 1'b0);
          if (pc.code == cfg.divide && pa.f2 == pc.f2)
            pc = reduce(pc, pa, ok_a, exp_a, cfg.shr_imm, 1'b0);
        end
      end
      if (pc.code == cfg.multiply || pb.code == cfg.multiply) begin
        if (pb.code == cfg.load_imm && (pb.f2 == pc.f2 || pb.f2 == pc.f1))
          pc = reduce(pc, pb, ok_b, exp_b, cfg.shl_imm, 1'b1);
        if (pa.code == cfg.load_imm) begin
          if (pb.code == cfg.multiply && (pa.f2 == pb.f2 || pa.f2 == pb.f1))
            pb = reduce(pb, pa, ok_a, exp_a, cfg.shl_imm, 1'b1);
          if (pc.code == cfg.multiply && (pa.f2 == pc.f2 || pa.f2 == pc.f1))
            pc = reduce(pc, pa, ok_a, exp_a, cfg.shl_imm, 1'b1);
        end
      end
    end
  end

  always_comb begin
    win_nxt[0]  = win_r[0];
    win_nxt[1]  = win_r[1];
    fill_nxt    = fill_r;
    q_data      = '0;
    q_data.eos  = in_item.end_of_stream;
    unique case (fill_r)
      2'd2: begin
        q_data.slot[0] = pa;
        q_data.slot[1] = pb;
        q_data.slot[2] = pc;
        q_data.cnt     = in_item.end_of_stream ? 2'd3 : 2'd1;
        win_nxt[0]     = pb;
        win_nxt[1]     = pc;
        fill_nxt       = in_item.end_of_stream ? 2'd0 : 2'd2;
      end
      2'd1: begin
        q_data.slot[0] = win_r[0];
        q_data.slot[1] = x;
        q_data.cnt     = in_item.end_of_stream ? 2'd2 : 2'd0;
        win_nxt[1]     = x;
        fill_nxt       = in_item.end_of_stream ? 2'd0 : 2'd2;
      end
      2'd0: begin
        q_data.slot[0] = x;
        q_data.cnt     = in_item.end_of_stream ? 2'd1 : 2'd0;
        win_nxt[0]     = x;
        fill_nxt       = in_item.end_of_stream ? 2'd0 : 2'd1;
      end
      default: begin
        fill_nxt = 2'd0;
      end
    endcase
  end

  assign q_push = accept && (q_data.cnt != 2'd0);

  always_ff @(posedge clk) begin
    if (accept) begin
      win_r[0] <= win_nxt[0];
      win_r[1] <= win_nxt[1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= 2'd0;
    end else if (accept) begin
      fill_r <= fill_nxt;
    end
  end

endmodule

// ===== src/pspr_queue.sv =====
// ----------------------------------------------------------------------------
// pspr_queue
// Short bundle queue between the front and back ends.
// ----------------------------------------------------------------------------
module pspr_queue import pspr_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    wr_en,
  input  bundle_t wr_data,
  output logic    full,
  input  logic    rd_en,
  output logic    valid,
  output bundle_t rd_data
);

  bundle_t           mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QPTR_W:0]   count_r;
  logic [QPTR_W:0]   count_nxt;
  logic              do_wr;
  logic              do_rd;

  assign full    = (count_r == (QPTR_W+1)'(QUEUE_DEPTH));
  assign valid   = (count_r != '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && valid;
  assign rd_data = mem[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (do_wr && !do_rd)      count_nxt = count_r + 1'b1;
    else if (do_rd && !do_wr) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (do_wr) mem[wr_ptr_r] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_wr) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (do_rd) rd_ptr_r <= rd_ptr_r + 1'b1;
      count_r <= count_nxt;
    end
  end

endmodule

// ===== src/pspr_back.sv =====
// ----------------------------------------------------------------------------
// pspr_back
// Unpacks bundles into single results and holds them in the output register.
// ----------------------------------------------------------------------------
module pspr_back import pspr_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      q_valid,
  input  bundle_t   q_head,
  output logic      q_pop,
  output logic      empty,
  input  logic      pop,
  output out_item_t out_item
);

  logic       out_valid_r;
  logic       out_valid_nxt;
  out_item_t  out_r;
  logic [1:0] idx_r;
  logic [1:0] idx_nxt;
  logic       load;
  logic       last_slot;
  insn_t      sel;

  assign last_slot = (idx_r == q_head.cnt - 2'd1);
  assign load      = q_valid && (!out_valid_r || pop);
  assign q_pop     = load && last_slot;
  assign sel       = q_head.slot[idx_r];
  assign empty     = !out_valid_r;
  assign out_item  = out_r;

  always_comb begin
    out_valid_nxt = out_valid_r;
    idx_nxt       = idx_r;
    if (load) begin
      out_valid_nxt = 1'b1;
      idx_nxt       = last_slot ? 2'd0 : idx_r + 2'd1;
    end else if (pop) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_r.out_op_code   <= sel.code;
      out_r.out_operand_a <= sel.f1;
      out_r.out_operand_b <= sel.f2;
      out_r.out_operand_c <= sel.f3;
      out_r.out_last      <= q_head.eos && last_slot;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      idx_r       <= 2'd0;
    end else begin
      out_valid_r <= out_valid_nxt;
      idx_r       <= idx_nxt;
    end
  end

endmodule

// ===== src/peephole_pow2_strength_reduce_unit.sv =====
// An instruction waits in the window until a later one or end of stream pushes it
// out, then goes via the queue to the output register. One instruction per cycle
// unless the queue is full; the back end drains one result per cycle while out_item
// is free, so the four-bundle queue absorbs end-of-stream flushes of three results.
// Reset (rst_n, synchronous, active low): clears window fill, queue, output
// valid flag and returns the opcode registers to their defaults.
// ----------------------------------------------------------------------------
// peephole_pow2_strength_reduce_unit
// Rewrites multiply/divide by a power-of-two load-immediate into shifts.
// ----------------------------------------------------------------------------
module peephole_pow2_strength_reduce_unit import pspr_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  output logic                  full,
  input  in_item_t              in_item,
  output logic                  empty,
  input  logic                  pop,
  output out_item_t             out_item,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  cfg_t    cfg;
  logic    q_push;
  bundle_t q_wdata;
  logic    q_full;
  logic    q_pop;
  logic    q_valid;
  bundle_t q_head;

  pspr_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  pspr_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .push    (push),
    .in_item (in_item),
    .q_full  (q_full),
    .full    (full),
    .q_push  (q_push),
    .q_data  (q_wdata)
  );

  pspr_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (q_push),
    .wr_data (q_wdata),
    .full    (q_full),
    .rd_en   (q_pop),
    .valid   (q_valid),
    .rd_data (q_head)
  );

  pspr_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_valid  (q_valid),
    .q_head   (q_head),
    .q_pop    (q_pop),
    .empty    (empty),
    .pop      (pop),
    .out_item (out_item)
  );

endmodule

// ===== src/pspr_checker.sv =====
// ----------------------------------------------------------------------------
// pspr_checker
// Port-level checks for the strength reduction unit, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pspr_checker import pspr_pkg::*; (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  full,
  input logic                  empty,
  input logic                  pop,
  input out_item_t             out_item,
  input logic                  psel,
  input logic                  penable,
  input logic                  pwrite,
  input logic [CFG_ADDR_W-1:0] paddr,
  input logic [CFG_DATA_W-1:0] pwdata,
  input logic [CFG_DATA_W-1:0] prdata,
  input logic                  pready
);

  logic              wr_load_imm;
  logic [CODE_W-1:0] wr_code_r;
  logic              rd_ok;

  // Capture the write data of every cycle for the readback check
  always_ff @(posedge clk) begin
    wr_code_r <= pwdata[CODE_W-1:0];
  end

  assign wr_load_imm = psel && penable && pwrite && pready && (paddr == '0);
  assign rd_ok       = (paddr != '0) || (prdata[CODE_W-1:0] == wr_code_r);

  // A full queue has been non-empty long enough to load the output register
  `ASSERT_IMPL(a_full_has_result, full, !empty, "queue full while no result is shown")

  // A stalled result transaction holds its payload
  `ASSERT_NEXT(a_out_hold, !empty && !pop, !empty && $stable(out_item), "stalled result changed")

  // A completed write to the load-immediate register reads back
  `ASSERT_NEXT(a_cfg_readback, wr_load_imm, rd_ok, "register readback mismatch")

endmodule

bind peephole_pow2_strength_reduce_unit pspr_checker u_pspr_checker (.*);
